/* rtl/bst_pkg.sv */
// Shared constants, codes and types for the block slot table.
package bst_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_SLOTS_DEF          = 64;
    localparam int BLOCK_NUMBER_WIDTH_DEF = 31;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int ST_W     = 2;
    localparam int OFF_W    = 11;
    localparam int LEN_W    = 11;
    localparam int ACT_W    = 7;
    localparam int MAXLEN_W = 11;

    // Register reset values
    localparam logic [ACT_W-1:0]    ACTIVE_RESET = 7'd64;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 11'd1024;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_MAXLEN = 1'b1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_NONE = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the request word
        logic match;    // build candidate vectors
        logic commit;   // pick a slot and update the table
        logic respond;  // load the result word
    } ctrl_cmd_t;

endpackage

/* rtl/bst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bst_ctrl.sv */
// Command sequencer: steps each request through match, commit and respond.
module bst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output bst_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_ENC   = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = start ? S_MATCH : S_IDLE;
            S_MATCH: state_next = S_ENC;
            S_ENC:   state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_RESP);
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.match   = (state_reg == S_MATCH);
    assign cmd.commit  = (state_reg == S_ENC);
    assign cmd.respond = (state_reg == S_RESP);

endmodule

/* rtl/bst_dp.sv */
// Slot table datapath: valid bits, tag compare row, priority pick, descriptor RAM.
module bst_dp #(
    parameter int NUM_SLOTS          = bst_pkg::NUM_SLOTS_DEF,
    parameter int BLOCK_NUMBER_WIDTH = bst_pkg::BLOCK_NUMBER_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bst_pkg::ctrl_cmd_t                   cmd,
    input  logic [bst_pkg::CMD_W-1:0]            command,
    input  logic [BLOCK_NUMBER_WIDTH-1:0]        block_number,
    input  logic [bst_pkg::OFF_W-1:0]            offset,
    input  logic [bst_pkg::LEN_W-1:0]            length,
    input  logic [bst_pkg::ACT_W-1:0]            active_slots,
    input  logic [bst_pkg::MAXLEN_W-1:0]         max_length,
    output logic [bst_pkg::ST_W-1:0]             status,
    output logic [$clog2(NUM_SLOTS)-1:0]         slot,
    output logic [BLOCK_NUMBER_WIDTH-1:0]        found_block_number,
    output logic [bst_pkg::OFF_W-1:0]            found_offset,
    output logic [bst_pkg::LEN_W-1:0]            found_length
);

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int BNW     = BLOCK_NUMBER_WIDTH;
    localparam int OFF_W   = bst_pkg::OFF_W;
    localparam int LEN_W   = bst_pkg::LEN_W;
    localparam int RAM_W   = BNW + OFF_W + LEN_W;
    localparam int CMP_W   = (SLOT_W + 1 > bst_pkg::ACT_W) ? SLOT_W + 1 : bst_pkg::ACT_W;

    // Request word
    logic [bst_pkg::CMD_W-1:0] cmd_reg;
    logic [BNW-1:0]            bn_reg;
    logic [OFF_W-1:0]          off_reg;
    logic [LEN_W-1:0]          len_reg;
    logic                      bad_reg;
    logic                      bad_next;

    // Table state
    logic [NUM_SLOTS-1:0]      valid_reg;
    logic [BNW-1:0]            tag_reg [NUM_SLOTS];
    logic [SLOT_W-1:0]         scan_reg;

    // Search pipeline
    logic [NUM_SLOTS-1:0]      cand_reg;
    logic [NUM_SLOTS-1:0]      cand_next;
    logic [NUM_SLOTS-1:0]      hi_reg;
    logic [NUM_SLOTS-1:0]      hi_next;
    logic [SLOT_W-1:0]         start_eff;
    logic [SLOT_W-1:0]         pick_next;
    logic                      found_next;
    logic [SLOT_W-1:0]         pick_reg;
    logic                      found_reg;

    // Descriptor RAM
    logic                      ram_we;
    logic [RAM_W-1:0]          ram_rdata;
    logic [BNW-1:0]            ram_bn;
    logic [OFF_W-1:0]          ram_off;
    logic [LEN_W-1:0]          ram_len;

    // Result word
    logic [bst_pkg::ST_W-1:0]  status_reg;
    logic [bst_pkg::ST_W-1:0]  status_next;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W-1:0]         slot_next;
    logic [BNW-1:0]            fbn_reg;
    logic [BNW-1:0]            fbn_next;
    logic [OFF_W-1:0]          foff_reg;
    logic [OFF_W-1:0]          foff_next;
    logic [LEN_W-1:0]          flen_reg;
    logic [LEN_W-1:0]          flen_next;

    // Lowest set bit
    function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] vec);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    assign bad_next = (command == bst_pkg::CMD_UNUSED) ||
                      ((command == bst_pkg::CMD_WRITE) &&
                       ((length > max_length) || (offset > length)));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= command;
            bn_reg  <= block_number;
            off_reg <= offset;
            len_reg <= length;
            bad_reg <= bad_next;
        end
    end

    // Saved scan start only counts while it lies inside the active slots
    assign start_eff = (CMP_W'(scan_reg) < CMP_W'(active_slots)) ? scan_reg : '0;

    always_comb
    begin
        logic act;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            act = (CMP_W'(i) < CMP_W'(active_slots));
            unique case (cmd_reg)
                bst_pkg::CMD_WRITE: cand_next[i] = !valid_reg[i] && act;
                bst_pkg::CMD_READ:  cand_next[i] = valid_reg[i] && act &&
                                                   (tag_reg[i] == bn_reg);
                bst_pkg::CMD_FETCH: cand_next[i] = valid_reg[i] && act;
                default:            cand_next[i] = 1'b0;
            endcase
            // Only a fetch starts above slot zero
            hi_next[i] = cand_next[i] && (cmd_reg == bst_pkg::CMD_FETCH) &&
                         (CMP_W'(i) >= CMP_W'(start_eff));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            cand_reg <= cand_next;
            hi_reg   <= hi_next;
        end
    end

    // Round-robin pick: first candidate at or above scan start, else wrap
    assign pick_next  = (|hi_reg) ? first_set(hi_reg) : first_set(cand_reg);
    assign found_next = |cand_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pick_reg  <= pick_next;
            found_reg <= found_next;
        end
    end

    assign ram_we = cmd.commit && !bad_reg && found_next && (cmd_reg == bst_pkg::CMD_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            scan_reg  <= '0;
        end
        else if (cmd.commit && !bad_reg)
        begin
            if (found_next)
            begin
                valid_reg[pick_next] <= (cmd_reg == bst_pkg::CMD_WRITE);
            end
            if (cmd_reg == bst_pkg::CMD_FETCH)
            begin
                scan_reg <= found_next ? pick_next : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            tag_reg[pick_next] <= bn_reg;
        end
    end

    bst_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pick_next),
        .wdata ({bn_reg, off_reg, len_reg}),
        .raddr (pick_next),
        .rdata (ram_rdata)
    );

    assign ram_len = ram_rdata[LEN_W-1:0];
    assign ram_off = ram_rdata[OFF_W+LEN_W-1:LEN_W];
    assign ram_bn  = ram_rdata[RAM_W-1:OFF_W+LEN_W];

    always_comb
    begin
        status_next = bst_pkg::ST_OK;
        slot_next   = '0;
        fbn_next    = '0;
        foff_next   = '0;
        flen_next   = '0;
        if (bad_reg)
        begin
            status_next = bst_pkg::ST_BAD;
        end
        else if (!found_reg)
        begin
            status_next = (cmd_reg == bst_pkg::CMD_WRITE) ? bst_pkg::ST_FULL
                                                          : bst_pkg::ST_NONE;
        end
        else
        begin
            slot_next = pick_reg;
            unique case (cmd_reg)
                bst_pkg::CMD_WRITE: flen_next = len_reg;
                bst_pkg::CMD_READ:  flen_next = ram_len;
                bst_pkg::CMD_FETCH:
                begin
                    fbn_next  = ram_bn;
                    foff_next = ram_off;
                    flen_next = ram_len;
                end
                default: status_next = bst_pkg::ST_BAD;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            fbn_reg    <= fbn_next;
            foff_reg   <= foff_next;
            flen_reg   <= flen_next;
        end
    end

    assign status             = status_reg;
    assign slot               = slot_reg;
    assign found_block_number = fbn_reg;
    assign found_offset       = foff_reg;
    assign found_length       = flen_reg;

endmodule

/* rtl/block_slot_table.sv */
// Block slot table: descriptor table with write, read-and-free and fetch-and-free.
//
// Request channel: drive command, block_number, offset and length with start
// high; the word is taken at a rising edge where start is high and busy is
// low. busy stays high until the result has been formed.
// Result channel: done pulses for exactly one cycle with status, slot and the
// found_* fields valid in that cycle. There is no backpressure; the receiver
// must take the word in that cycle.
// Sequence: after the accepting edge a request passes through match, pick and
// commit, RAM read and format; then done goes high, and the word is taken at
// the edge that ends done. busy drops with done, so a new request is taken at
// that same edge. The pick stage feeds the registered RAM read.
// Slot choice: a compare row over the stored block numbers and the valid
// bits builds a candidate vector, registered, then a priority pick chooses the
// lowest slot (write, read) or the first slot from the saved scan start with
// wrap (fetch). The slot index goes out so an outside data store can be
// addressed.
// Config: APB, active_slots at 0x0, max_length at 0x4; write only while idle.
// Reset: every slot free, scan start at zero, registers at 64 and 1024; no
// clearing pass is needed, the descriptor RAM is read only through valid slots.
module block_slot_table #(
    parameter int NUM_SLOTS          = bst_pkg::NUM_SLOTS_DEF,
    parameter int BLOCK_NUMBER_WIDTH = bst_pkg::BLOCK_NUMBER_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bst_pkg::PADDR_W-1:0]          paddr,
    input  logic [bst_pkg::PDATA_W-1:0]          pwdata,
    output logic [bst_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    // Request
    input  logic                                 start,
    output logic                                 busy,
    input  logic [bst_pkg::CMD_W-1:0]            command,
    input  logic [BLOCK_NUMBER_WIDTH-1:0]        block_number,
    input  logic [bst_pkg::OFF_W-1:0]            offset,
    input  logic [bst_pkg::LEN_W-1:0]            length,
    // Result
    output logic                                 done,
    output logic [bst_pkg::ST_W-1:0]             status,
    output logic [$clog2(NUM_SLOTS)-1:0]         slot,
    output logic [BLOCK_NUMBER_WIDTH-1:0]        found_block_number,
    output logic [bst_pkg::OFF_W-1:0]            found_offset,
    output logic [bst_pkg::LEN_W-1:0]            found_length
);

    logic [bst_pkg::ACT_W-1:0]    active_reg;
    logic [bst_pkg::MAXLEN_W-1:0] maxlen_reg;
    logic                         cfg_wr;
    logic                         reg_sel;
    bst_pkg::ctrl_cmd_t           cmd;

    // Register index is the word address
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= bst_pkg::ACTIVE_RESET;
            maxlen_reg <= bst_pkg::MAXLEN_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == bst_pkg::REG_ACTIVE)
            begin
                active_reg <= pwdata[bst_pkg::ACT_W-1:0];
            end
            else
            begin
                maxlen_reg <= pwdata[bst_pkg::MAXLEN_W-1:0];
            end
        end
    end

    assign prdata = (reg_sel == bst_pkg::REG_MAXLEN)
                  ? bst_pkg::PDATA_W'(maxlen_reg)
                  : bst_pkg::PDATA_W'(active_reg);

    bst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    bst_dp #(
        .NUM_SLOTS          (NUM_SLOTS),
        .BLOCK_NUMBER_WIDTH (BLOCK_NUMBER_WIDTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .command            (command),
        .block_number       (block_number),
        .offset             (offset),
        .length             (length),
        .active_slots       (active_reg),
        .max_length         (maxlen_reg),
        .status             (status),
        .slot               (slot),
        .found_block_number (found_block_number),
        .found_offset       (found_offset),
        .found_length       (found_length)
    );

endmodule

/* rtl/bst_checker.sv */
// Port-level checker for the block slot table, with its bind.
module bst_checker #(
    parameter int NUM_SLOTS          = bst_pkg::NUM_SLOTS_DEF,
    parameter int BLOCK_NUMBER_WIDTH = bst_pkg::BLOCK_NUMBER_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic [bst_pkg::ST_W-1:0]      status,
    input  logic [$clog2(NUM_SLOTS)-1:0]  slot,
    input  logic [BLOCK_NUMBER_WIDTH-1:0] found_block_number,
    input  logic [bst_pkg::OFF_W-1:0]     found_offset,
    input  logic [bst_pkg::LEN_W-1:0]     found_length
);

    // Every accepted word is answered with a result word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result word not delivered four cycles after accept");

    // A result closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result word outside a busy period");

    // Failed commands carry no slot or descriptor
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != bst_pkg::ST_OK)) |->
        ((slot == '0) && (found_block_number == '0) &&
         (found_offset == '0) && (found_length == '0)))
        else $error("failed command returned nonzero fields");

    // No accept while a command is in flight
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy ##1 busy ##1 busy))
        else $error("busy dropped during a command");

endmodule

bind block_slot_table bst_checker #(
    .NUM_SLOTS          (NUM_SLOTS),
    .BLOCK_NUMBER_WIDTH (BLOCK_NUMBER_WIDTH)
) u_bst_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .status             (status),
    .slot               (slot),
    .found_block_number (found_block_number),
    .found_offset       (found_offset),
    .found_length       (found_length)
);
